// ===== sv/scc_pkg.sv =====
// shared types and constants of the sector cache clock controller
// no dependencies; imported by every module of the block
package scc_pkg;

  // fixed field widths of the transaction payloads
  localparam int unsigned OP_W     = 2;
  localparam int unsigned SECTOR_W = 32;
  localparam int unsigned SLOT_W   = 6;

  // slots examined per lookup cycle, one tag bank each
  localparam int unsigned LANES  = 8;
  localparam int unsigned LANE_W = $clog2(LANES);

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // input transaction
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [SECTOR_W-1:0] sector_number;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [SLOT_W-1:0]   slot;
    logic                hit;
    logic                fill;
    logic                writeback_valid;
    logic [SLOT_W-1:0]   writeback_slot;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                last;
  } out_t;

  // datapath commands issued by the controller
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_START,
    CMD_SCAN,
    CMD_HIT,
    CMD_CLOCK,
    CMD_VREAD,
    CMD_INSTALL,
    CMD_FL_TAKE,
    CMD_FL_NEXT,
    CMD_FL_END
  } cmd_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic out_free;
    logic scan_match;
    logic row_last;
    logic empty_known;
    logic ref_at_hand;
    logic pend_any;
    logic stage_valid;
  } dp_status_t;

endpackage

// ===== sv/scc_ctrl.sv =====
// controller state machine of the sector cache clock controller
// depends on scc_pkg; drives datapath commands from datapath status
module scc_ctrl import scc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  input  dp_status_t      status_i,
  output cmd_e            cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_HIT,
    S_CLOCK,
    S_VREAD,
    S_INSTALL,
    S_FLUSH,
    S_FL_END
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_IDLE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_op_i) inside
            OP_READ, OP_WRITE: begin
              cmd_o   = CMD_START;
              state_d = S_LOOKUP;
            end
            OP_FLUSH: begin
              cmd_o   = CMD_START;
              state_d = S_FLUSH;
            end
            default: begin
              // unused code: taken and dropped
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_LOOKUP: begin
        cmd_o = CMD_SCAN;
        if (status_i.scan_match) begin
          state_d = S_HIT;
        end else if (status_i.row_last) begin
          state_d = status_i.empty_known ? S_INSTALL : S_CLOCK;
        end
      end
      S_HIT: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_HIT;
          state_d = S_IDLE;
        end
      end
      S_CLOCK: begin
        cmd_o = CMD_CLOCK;
        if (!status_i.ref_at_hand) begin
          state_d = S_VREAD;
        end
      end
      S_VREAD: begin
        cmd_o   = CMD_VREAD;
        state_d = S_INSTALL;
      end
      S_INSTALL: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_INSTALL;
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (status_i.pend_any) begin
          if (!status_i.stage_valid || status_i.out_free) begin
            cmd_o = CMD_FL_TAKE;
          end
        end else if (!status_i.row_last) begin
          cmd_o = CMD_FL_NEXT;
        end else begin
          state_d = S_FL_END;
        end
      end
      S_FL_END: begin
        if (status_i.out_free) begin
          cmd_o   = CMD_FL_END;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/scc_dp.sv =====
// datapath of the sector cache clock controller: slot flags, banked tag store,
// clock hand, lookup and flush scan, flush staging and result register; uses scc_pkg
module scc_dp import scc_pkg::*; #(
  parameter int unsigned SLOTS       = 64,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_e       cmd_i,
  input  in_t        in_data_i,
  output dp_status_t status_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_t       out_data_o
);

  localparam int unsigned ROWS   = (SLOTS + LANES - 1) / LANES;
  localparam int unsigned PSLOTS = ROWS * LANES;
  localparam int unsigned IDX_W  = $clog2(PSLOTS);
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [PSLOTS-1:0] EXISTS    = {PSLOTS{1'b1}} >> (PSLOTS - SLOTS);
  localparam logic [IDX_W-1:0]  LAST_SLOT = IDX_W'(SLOTS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  // slot number from row and lane
  function automatic logic [IDX_W-1:0] slot_of(input logic [ROW_W-1:0]  r,
                                               input logic [LANE_W-1:0] l);
    return IDX_W'({r, l});
  endfunction

  // lowest set lane
  function automatic logic [LANE_W-1:0] first_lane(input logic [LANES-1:0] v);
    logic [LANE_W-1:0] r;
    r = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (v[i]) r = LANE_W'(i);
    end
    return r;
  endfunction

  // flush result for one written-back slot
  function automatic out_t wb_result(input logic [IDX_W-1:0]       s,
                                     input logic [SECTOR_BITS-1:0] tag,
                                     input logic                   last);
    out_t r;
    r                  = '0;
    r.slot             = SLOT_W'(s);
    r.writeback_valid  = 1'b1;
    r.writeback_slot   = SLOT_W'(s);
    r.writeback_sector = SECTOR_W'(tag);
    r.last             = last;
    return r;
  endfunction

  // control state
  logic [PSLOTS-1:0] valid_q, valid_d, dirty_q, dirty_d, ref_q, ref_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [IDX_W-1:0]  hand_q, hand_d;
  logic              empty_found_q, empty_found_d;
  logic [LANES-1:0]  pend_q, pend_d;
  logic              stage_valid_q, stage_valid_d;
  logic              out_valid_q, out_valid_d;

  // payload state
  logic [SECTOR_BITS-1:0] sector_q, sector_d;
  logic                   write_q, write_d;
  logic [IDX_W-1:0]       tgt_q, tgt_d;
  logic [IDX_W-1:0]       stage_slot_q, stage_slot_d;
  logic [SECTOR_BITS-1:0] stage_tag_q, stage_tag_d;
  out_t                   out_q, out_d;

  // tag store ports
  logic                   rd_en, wr_en;
  logic [ROW_W-1:0]       rd_row, wr_row;
  logic [LANE_W-1:0]      wr_lane;
  logic [SECTOR_BITS-1:0] wr_tag;
  logic [SECTOR_BITS-1:0] rd_tag_q [LANES];

  // tag banks, one per lane, all read at the same row
  for (genvar l = 0; l < LANES; l++) begin : g_bank
    logic [SECTOR_BITS-1:0] mem [ROWS];
    always_ff @(posedge clk_i) begin
      if (wr_en && (wr_lane == LANE_W'(l))) begin
        mem[wr_row] <= wr_tag;
      end
      if (rd_en) begin
        rd_tag_q[l] <= mem[rd_row];
      end
    end
  end

  // row views of the flags
  logic [IDX_W-1:0]  row_base, next_base;
  logic [ROW_W-1:0]  row_inc;
  logic [PSLOTS-1:0] flushable;
  logic [LANES-1:0]  row_valid, row_empty, row_match;
  logic              match_any, empty_any;
  logic [LANE_W-1:0] match_lane, empty_lane, pend_lane, tgt_lane;
  logic [ROW_W-1:0]  tgt_row;
  logic [IDX_W-1:0]  hand_next, take_slot;
  logic              push;
  out_t              push_data;

  assign row_inc   = row_q + 1'b1;
  assign row_base  = slot_of(row_q, '0);
  assign next_base = slot_of(row_inc, '0);
  assign flushable = valid_q & dirty_q & EXISTS;
  assign row_valid = valid_q[row_base +: LANES] & EXISTS[row_base +: LANES];
  assign row_empty = ~valid_q[row_base +: LANES] & EXISTS[row_base +: LANES];

  // tag compare across the lanes of the row just read
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      row_match[l] = row_valid[l] && (rd_tag_q[l] == sector_q);
    end
  end

  assign match_any  = |row_match;
  assign empty_any  = |row_empty;
  assign match_lane = first_lane(row_match);
  assign empty_lane = first_lane(row_empty);
  assign pend_lane  = first_lane(pend_q);
  assign take_slot  = slot_of(row_q, pend_lane);
  assign tgt_lane   = tgt_q[LANE_W-1:0];
  assign tgt_row    = ROW_W'(tgt_q >> LANE_W);
  assign hand_next  = (hand_q == LAST_SLOT) ? '0 : hand_q + 1'b1;

  // command decode
  always_comb begin
    valid_d       = valid_q;
    dirty_d       = dirty_q;
    ref_d         = ref_q;
    row_d         = row_q;
    hand_d        = hand_q;
    empty_found_d = empty_found_q;
    pend_d        = pend_q;
    stage_valid_d = stage_valid_q;
    sector_d      = sector_q;
    write_d       = write_q;
    tgt_d         = tgt_q;
    stage_slot_d  = stage_slot_q;
    stage_tag_d   = stage_tag_q;
    rd_en         = 1'b0;
    rd_row        = row_q;
    wr_en         = 1'b0;
    wr_row        = tgt_row;
    wr_lane       = tgt_lane;
    wr_tag        = sector_q;
    push          = 1'b0;
    push_data     = '0;
    unique case (cmd_i)
      CMD_START: begin
        sector_d      = SECTOR_BITS'(in_data_i.sector_number);
        write_d       = (in_data_i.op == OP_WRITE);
        row_d         = '0;
        rd_en         = 1'b1;
        rd_row        = '0;
        empty_found_d = 1'b0;
        stage_valid_d = 1'b0;
        pend_d        = flushable[LANES-1:0];
      end
      CMD_SCAN: begin
        if (row_q != LAST_ROW) begin
          rd_en  = 1'b1;
          rd_row = row_inc;
          row_d  = row_inc;
        end
        if (match_any) begin
          tgt_d = slot_of(row_q, match_lane);
        end else if (!empty_found_q && empty_any) begin
          tgt_d         = slot_of(row_q, empty_lane);
          empty_found_d = 1'b1;
        end
      end
      CMD_HIT: begin
        ref_d[tgt_q] = 1'b1;
        if (write_q) dirty_d[tgt_q] = 1'b1;
        push           = 1'b1;
        push_data.slot = SLOT_W'(tgt_q);
        push_data.hit  = 1'b1;
        push_data.last = 1'b1;
      end
      CMD_CLOCK: begin
        if (ref_q[hand_q]) begin
          ref_d[hand_q] = 1'b0;
        end else begin
          tgt_d = hand_q;
        end
        hand_d = hand_next;
      end
      CMD_VREAD: begin
        rd_en  = 1'b1;
        rd_row = tgt_row;
      end
      CMD_INSTALL: begin
        wr_en          = 1'b1;
        valid_d[tgt_q] = 1'b1;
        dirty_d[tgt_q] = write_q;
        ref_d[tgt_q]   = 1'b1;
        push           = 1'b1;
        push_data.slot = SLOT_W'(tgt_q);
        push_data.fill = 1'b1;
        push_data.last = 1'b1;
        // an empty slot is never dirty, so only a victim writes back
        if (dirty_q[tgt_q]) begin
          push_data.writeback_valid  = 1'b1;
          push_data.writeback_slot   = SLOT_W'(tgt_q);
          push_data.writeback_sector = SECTOR_W'(rd_tag_q[tgt_lane]);
        end
      end
      CMD_FL_TAKE: begin
        if (stage_valid_q) begin
          push      = 1'b1;
          push_data = wb_result(stage_slot_q, stage_tag_q, 1'b0);
        end
        stage_valid_d      = 1'b1;
        stage_slot_d       = take_slot;
        stage_tag_d        = rd_tag_q[pend_lane];
        valid_d[take_slot] = 1'b0;
        dirty_d[take_slot] = 1'b0;
        ref_d[take_slot]   = 1'b0;
        pend_d[pend_lane]  = 1'b0;
      end
      CMD_FL_NEXT: begin
        row_d  = row_inc;
        rd_en  = 1'b1;
        rd_row = row_inc;
        pend_d = flushable[next_base +: LANES];
      end
      CMD_FL_END: begin
        push = 1'b1;
        if (stage_valid_q) begin
          push_data = wb_result(stage_slot_q, stage_tag_q, 1'b1);
        end else begin
          push_data.last = 1'b1;
        end
        stage_valid_d = 1'b0;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // result register
  always_comb begin
    out_d       = push ? push_data : out_q;
    out_valid_d = push ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q       <= '0;
      dirty_q       <= '0;
      ref_q         <= '0;
      row_q         <= '0;
      hand_q        <= '0;
      empty_found_q <= 1'b0;
      pend_q        <= '0;
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      valid_q       <= valid_d;
      dirty_q       <= dirty_d;
      ref_q         <= ref_d;
      row_q         <= row_d;
      hand_q        <= hand_d;
      empty_found_q <= empty_found_d;
      pend_q        <= pend_d;
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sector_q     <= sector_d;
    write_q      <= write_d;
    tgt_q        <= tgt_d;
    stage_slot_q <= stage_slot_d;
    stage_tag_q  <= stage_tag_d;
    out_q        <= out_d;
  end

  // status back to the controller
  assign status_o.out_free    = !out_valid_q || out_ready_i;
  assign status_o.scan_match  = match_any;
  assign status_o.row_last    = (row_q == LAST_ROW);
  assign status_o.empty_known = empty_found_q || empty_any;
  assign status_o.ref_at_hand = ref_q[hand_q];
  assign status_o.pend_any    = |pend_q;
  assign status_o.stage_valid = stage_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/sector_cache_clock_controller.sv =====
// Fully associative sector cache controller with clock replacement. One
// request is handled at a time. Tags sit in eight banks read a row of eight
// slots per cycle. A lookup scans the rows in order and stops at the first
// hit; a miss scans every row (ROWS = SLOTS/8 rounded up, 8 rows at 64 slots)
// and fills an empty slot if one was seen, else the clock hand clears the
// reference bits it passes until it finds an unreferenced victim, whose tag is
// read before the install. A flush visits every row and writes back each dirty
// slot, then gives a final result. The result register lets a new request be
// taken while the last result still waits; back-pressure on the result side
// stalls only the step that must deliver. No clearing pass follows reset.
// depends on scc_pkg, scc_ctrl and scc_dp
module sector_cache_clock_controller import scc_pkg::*; #(
  parameter int unsigned SLOTS       = 64,
  parameter int unsigned SECTOR_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_e       cmd;
  dp_status_t status;

  // controller
  scc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  scc_dp #(
    .SLOTS       (SLOTS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  // checks on controller and datapath cooperation
  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.op == OP_READ || in_data_i.op == OP_WRITE ||
               in_data_i.op == OP_FLUSH) |=> !in_ready_o)
    else $error("request accepted but controller stayed ready");

  a_unused_op_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.op == OP_NONE) |=> in_ready_o)
    else $error("unused request code left the controller busy");

  a_push_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_HIT || cmd == CMD_INSTALL || cmd == CMD_FL_END) |-> status.out_free)
    else $error("result pushed over an untaken result");

  a_stage_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd == CMD_FL_TAKE) && status.stage_valid |-> status.out_free)
    else $error("staged flush result pushed over an untaken result");

endmodule
